>>> src/rlt_pkg.sv
// Shared types and constants for the resource lock table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package rlt_pkg;

	localparam int unsigned OWNER_W  = 8;
	localparam int unsigned RES_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned COUNT_W  = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	// request codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BLOCKED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd3;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic               valid;
		logic [OWNER_W-1:0] owner;
		logic [RES_W-1:0]   resource;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FIX,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic scan;
		logic grant;
		logic block;
		logic full;
		logic rel_done;
		logic drop_hit;
		logic publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic addr_last;
		logic ev_valid;
		logic last_eval;
		logic release_op;
		logic hit_res;
		logic hit_same;
		logic free_found;
		logic free_any;
	} sts_t;

endpackage

`default_nettype wire

>>> src/rlt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rlt_ram #(
	parameter int unsigned WIDTH = 25,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/rlt_ctrl.sv
// Sequencer for the resource lock table: clearing pass, scan, fix-up, response.
// Depends on rlt_pkg.
`default_nettype none

module rlt_ctrl import rlt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	state_t state_q, state_next;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.addr_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.ev_valid) begin
					if (sts.release_op) begin
						if (sts.last_eval) begin
							cmd.rel_done = 1'b1;
							state_next   = S_RESP;
						end
					end else if (sts.hit_res && !sts.hit_same) begin
						cmd.block  = 1'b1;
						state_next = S_RESP;
					end else if (sts.hit_res) begin
						// same owner: move to an earlier free entry if there is one
						cmd.grant  = 1'b1;
						state_next = sts.free_found ? S_FIX : S_RESP;
					end else if (sts.last_eval) begin
						cmd.grant  = sts.free_any;
						cmd.full   = !sts.free_any;
						state_next = S_RESP;
					end
				end
			end
			S_FIX: begin
				cmd.drop_hit = 1'b1;
				state_next   = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_next  = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> src/rlt_dp.sv
// Datapath of the resource lock table: entry RAM, scan pointer, match and free
// tracking, pending result and output register. Depends on rlt_pkg and rlt_ram.
`default_nettype none

module rlt_dp import rlt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 64,
	localparam int unsigned IW = $clog2(TABLE_ENTRIES),
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic               op,
	input  wire logic [OWNER_W-1:0] owner_id,
	input  wire logic [RES_W-1:0]   resource_id,
	output logic [STATUS_W-1:0]     status,
	output logic [SLOT_W-1:0]       slot,
	output logic [COUNT_W-1:0]      released_count
);

	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	// scan state
	logic [IW-1:0] rd_addr_q;
	logic          issue_q;
	logic [IW-1:0] addr_s1;
	logic          vld_s1;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] hit_idx_q;
	logic [CW-1:0] cnt_q;

	// request
	logic               op_q;
	logic [OWNER_W-1:0] owner_q;
	logic [RES_W-1:0]   res_q;

	// pending and published result
	logic [STATUS_W-1:0] pend_status_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [COUNT_W-1:0]  pend_count_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  count_q;

	// RAM ports
	logic                      we;
	logic [IW-1:0]             waddr;
	entry_t                    wdata;
	logic [$bits(entry_t)-1:0] rdata;
	entry_t                    ent;

	logic          hit_res, hit_same, hit_own, is_free, rel_hit;
	logic [IW-1:0] free_sel;
	logic [CW-1:0] cnt_next;
	logic [COUNT_W-1:0] count_sat;

	rlt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign ent      = entry_t'(rdata);
	assign hit_same = (ent.owner == owner_q);
	assign hit_res  = ent.valid && (ent.resource == res_q);
	assign hit_own  = ent.valid && hit_same;
	assign is_free  = !ent.valid;
	assign rel_hit  = vld_s1 && hit_own && (op_q == OP_RELEASE);
	assign free_sel = free_found_q ? free_idx_q : addr_s1;
	assign cnt_next = cnt_q + CW'(rel_hit);

	always_comb begin
		if (32'(cnt_next) > 32'(COUNT_MAX)) begin
			count_sat = COUNT_MAX;
		end else begin
			count_sat = COUNT_W'(cnt_next);
		end
	end

	// single write port: clear, grant, drop of a moved entry, release
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		if (cmd.clear_step) begin
			we    = 1'b1;
			waddr = rd_addr_q;
		end else if (cmd.grant) begin
			we             = 1'b1;
			waddr          = free_sel;
			wdata.valid    = 1'b1;
			wdata.owner    = owner_q;
			wdata.resource = res_q;
		end else if (cmd.drop_hit) begin
			we    = 1'b1;
			waddr = hit_idx_q;
		end else if (cmd.scan && rel_hit) begin
			we    = 1'b1;
			waddr = addr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q    <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else if (cmd.clear_step) begin
			rd_addr_q <= rd_addr_q + IW'(1);
		end else if (cmd.load) begin
			rd_addr_q    <= '0;
			issue_q      <= 1'b1;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else if (cmd.scan) begin
			vld_s1 <= issue_q;
			if (issue_q) begin
				rd_addr_q <= rd_addr_q + IW'(1);
				if (rd_addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (vld_s1 && is_free && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			owner_q <= owner_id;
			res_q   <= resource_id;
		end
		if (cmd.scan) begin
			addr_s1 <= rd_addr_q;
			if (vld_s1 && is_free && !free_found_q) begin
				free_idx_q <= addr_s1;
			end
		end
		if (cmd.grant) begin
			pend_status_q <= STATUS_GRANTED;
			pend_slot_q   <= SLOT_W'(free_sel);
			pend_count_q  <= '0;
			hit_idx_q     <= addr_s1;
		end
		if (cmd.block) begin
			pend_status_q <= STATUS_BLOCKED;
			pend_slot_q   <= SLOT_W'(addr_s1);
			pend_count_q  <= '0;
		end
		if (cmd.full) begin
			pend_status_q <= STATUS_FULL;
			pend_slot_q   <= '0;
			pend_count_q  <= '0;
		end
		if (cmd.rel_done) begin
			pend_status_q <= STATUS_RELEASED;
			pend_slot_q   <= '0;
			pend_count_q  <= count_sat;
		end
		if (cmd.publish) begin
			status_q <= pend_status_q;
			slot_q   <= pend_slot_q;
			count_q  <= pend_count_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.addr_last  = (rd_addr_q == LAST_IDX);
		sts.ev_valid   = vld_s1;
		sts.last_eval  = (addr_s1 == LAST_IDX);
		sts.release_op = (op_q == OP_RELEASE);
		sts.hit_res    = hit_res;
		sts.hit_same   = hit_same;
		sts.free_found = free_found_q;
		sts.free_any   = free_found_q || is_free;
	end

	assign status         = status_q;
	assign slot           = slot_q;
	assign released_count = count_q;

endmodule

`default_nettype wire

>>> src/resource_lock_table_unit.sv
// Scan: an acquire can stop at the first entry that decides it;
//   a release_all always scans the whole table.
// Flow: one request at a time, the next after the publish; a stalled result delays it.
// Reset: arst_n clears control state, then a clearing pass zeroes every entry;
//   in_ready stays low until it ends.
// Top level; depends on rlt_pkg, rlt_ctrl, rlt_dp (and rlt_ram below it).
`default_nettype none

module resource_lock_table_unit import rlt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic [OWNER_W-1:0] owner_id,
	input  wire logic [RES_W-1:0]   resource_id,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STATUS_W-1:0]     status,
	output logic [SLOT_W-1:0]       slot,
	output logic [COUNT_W-1:0]      released_count
);

	// Command and status between the sequencer and the datapath.
	// The sequencer owns the handshakes; the datapath holds the table,
	// the scan pointer and the result registers.
	cmd_t cmd;
	sts_t sts;

	// Sequencer: clear the table after reset, take a request in idle,
	// advance the scan until an entry or the table end decides, optionally drop
	// the entry that a same-owner re-acquire moved, then hold the result until the
	// output register is free. A new request is taken while the previous
	// result still waits in the output register.
	rlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: entry RAM with registered read, first-free tracking,
	// release counter with saturation, pending and output result.
	rlt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.owner_id       (owner_id),
		.resource_id    (resource_id),
		.status         (status),
		.slot           (slot),
		.released_count (released_count)
	);

endmodule

`default_nettype wire

>>> src/rlt_checker.sv
// Port-level checks for resource_lock_table_unit, attached with a bind.
// Depends on rlt_pkg.
`default_nettype none

module rlt_checker import rlt_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [SLOT_W-1:0]   slot,
	input wire logic [COUNT_W-1:0]  released_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
			&& $stable(released_count))
		else $error("result changed while stalled");

	// one request in flight: the block goes busy after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// only a release reports a count
	a_count_release_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_RELEASED) |-> released_count == '0)
		else $error("count on a non-release result");

	// full and release carry no slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL || status == STATUS_RELEASED) |-> slot == '0)
		else $error("slot set on full or release result");

endmodule

bind resource_lock_table_unit rlt_checker u_rlt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.slot           (slot),
	.released_count (released_count)
);

`default_nettype wire

>>> test/resource_lock_table_unit_checker.sv
// Scoreboard for the resource lock table: watches both channels, keeps its own
// copy of the table and compares every result with the predicted one.
// Depends on rlt_pkg for field widths and status codes.

module resource_lock_table_unit_checker import rlt_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               op,
	input  wire logic [OWNER_W-1:0] owner_id,
	input  wire logic [RES_W-1:0]   resource_id,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic [SLOT_W-1:0]  slot,
	input  wire logic [COUNT_W-1:0] released_count,
	output int                      fail_count,
	output int                      waiting,
	output int                      n_granted,
	output int                      n_blocked,
	output int                      n_full,
	output int                      n_released
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  count;
	} lock_result_t;

	lock_result_t        pending_results[$];
	logic                held_valid[ENTRIES];
	logic [OWNER_W-1:0]  held_owner[ENTRIES];
	logic [RES_W-1:0]    held_res[ENTRIES];

	int mismatches = 0;
	int grants = 0, blocks = 0, fulls = 0, releases = 0;
	int queued = 0;

	assign fail_count = mismatches;
	assign waiting    = queued;
	assign n_granted  = grants;
	assign n_blocked  = blocks;
	assign n_full     = fulls;
	assign n_released = releases;

	// Apply one request to the shadow table and return the result it must produce.
	function automatic lock_result_t predict_lock(input logic req_op,
			input logic [OWNER_W-1:0] who, input logic [RES_W-1:0] res);
		lock_result_t r;
		int freed;
		bit blocked;
		r = '0;
		freed = 0;
		blocked = 0;
		if (req_op == OP_RELEASE) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (held_valid[i] && held_owner[i] == who) begin
					held_valid[i] = 1'b0;
					freed++;
				end
			end
			r.status = STATUS_RELEASED;
			r.count  = (freed > 127) ? COUNT_MAX : freed[COUNT_W-1:0];
		end else begin
			// first holder of the resource decides; own entry is dropped and re-granted
			for (int i = 0; i < ENTRIES; i++) begin
				if (held_valid[i] && held_res[i] == res) begin
					if (held_owner[i] != who) begin
						blocked = 1;
						r.slot = i[SLOT_W-1:0];
					end else begin
						held_valid[i] = 1'b0;
					end
					break;
				end
			end
			if (blocked) begin
				r.status = STATUS_BLOCKED;
			end else begin
				r.status = STATUS_FULL;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!held_valid[i]) begin
						held_valid[i] = 1'b1;
						held_owner[i] = who;
						held_res[i]   = res;
						r.status = STATUS_GRANTED;
						r.slot   = i[SLOT_W-1:0];
						break;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lock_result_t got;
		lock_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				held_valid[i] = 1'b0;
				held_owner[i] = '0;
				held_res[i]   = '0;
			end
			pending_results.delete();
		end else begin
			// check the result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				got.status = status;
				got.slot   = slot;
				got.count  = released_count;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"checker: result with nothing pending: ",
							"status %0d slot %0d count %0d"},
							got.status, got.slot, got.count);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"checker: mismatch: status exp %0d got %0d, ",
								"slot exp %0d got %0d, count exp %0d got %0d"},
								want.status, got.status, want.slot, got.slot,
								want.count, got.count);
					end
				end
			end
			// predict every accepted request
			if (in_valid && in_ready) begin
				want = predict_lock(op, owner_id, resource_id);
				pending_results.push_back(want);
				case (want.status)
					STATUS_GRANTED: grants++;
					STATUS_BLOCKED: blocks++;
					STATUS_FULL:    fulls++;
					default:        releases++;
				endcase
			end
		end
		queued = pending_results.size();
	end

endmodule

>>> test/resource_lock_table_unit_tb.sv
// Top of the lock table testbench: clock, reset, request stimulus, result-side
// back-pressure and the verdict. Depends on rlt_pkg, the block and the checker.

module resource_lock_table_unit_tb;
	import rlt_pkg::*;

	localparam int unsigned ENTRIES = 64;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_ACQUIRE;
	logic [OWNER_W-1:0] owner_id = '0;
	logic [RES_W-1:0]   resource_id = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]  slot;
	logic [COUNT_W-1:0] released_count;

	int fail_count, waiting, n_granted, n_blocked, n_full, n_released;

	// while set, neither side inserts gaps: back-to-back transfers
	bit steady = 1'b0;
	int sent = 0;

	resource_lock_table_unit #(.TABLE_ENTRIES(ENTRIES)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.owner_id       (owner_id),
		.resource_id    (resource_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot           (slot),
		.released_count (released_count)
	);

	resource_lock_table_unit_checker #(.ENTRIES(ENTRIES)) lock_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.owner_id       (owner_id),
		.resource_id    (resource_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot           (slot),
		.released_count (released_count),
		.fail_count     (fail_count),
		.waiting        (waiting),
		.n_granted      (n_granted),
		.n_blocked      (n_blocked),
		.n_full         (n_full),
		.n_released     (n_released)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none while steady.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request at a falling edge and hold it until the transfer.
	// Keep valid high across back-to-back requests instead of dropping it.
	task automatic send_req(input logic req_op, input logic [OWNER_W-1:0] who,
			input logic [RES_W-1:0] res);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		op          <= req_op;
		owner_id    <= who;
		resource_id <= res;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Small pools of owners and resources fighting over the same entries;
	// release every owner of the pool at the end to drain the table.
	task automatic contention_burst(input int n);
		logic [OWNER_W-1:0] obase;
		logic [RES_W-1:0]   rbase;
		obase = OWNER_W'($urandom_range(0, 249));
		rbase = RES_W'($urandom_range(0, 65535));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15)
				send_req(OP_RELEASE, obase + OWNER_W'($urandom_range(0, 5)),
					RES_W'($urandom_range(0, 65535)));
			else
				send_req(OP_ACQUIRE, obase + OWNER_W'($urandom_range(0, 5)),
					rbase + RES_W'($urandom_range(0, 15)));
		end
		for (int k = 0; k < 6; k++)
			send_req(OP_RELEASE, obase + OWNER_W'(k), RES_W'($urandom_range(0, 65535)));
	endtask

	// Push past the table size so full-table rejects show up, then free it.
	task automatic fill_table();
		logic [OWNER_W-1:0] who[3];
		logic [RES_W-1:0]   rbase;
		rbase = RES_W'($urandom_range(0, 65535));
		for (int k = 0; k < 3; k++)
			who[k] = OWNER_W'($urandom_range(0, 255));
		for (int i = 0; i < ENTRIES + 6; i++)
			send_req(OP_ACQUIRE, who[2'(i % 3)], rbase + RES_W'(i));
		for (int k = 0; k < 3; k++)
			send_req(OP_RELEASE, who[k], RES_W'($urandom_range(0, 65535)));
	endtask

	// Full-range resources and random ops over a few random owners.
	task automatic noise_burst(input int n);
		logic [OWNER_W-1:0] who[4];
		for (int k = 0; k < 4; k++)
			who[k] = OWNER_W'($urandom_range(0, 255));
		for (int i = 0; i < n; i++)
			send_req(1'($urandom_range(0, 1)), who[2'($urandom_range(0, 3))],
				RES_W'($urandom_range(0, 65535)));
		for (int k = 0; k < 4; k++)
			send_req(OP_RELEASE, who[k], RES_W'($urandom_range(0, 65535)));
	endtask

	// Result side: random stalls between stretches of ready.
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	end

	initial begin
		int roll;
		int waited;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, blocking, same-owner re-acquire
		send_req(OP_ACQUIRE, 8'd0, 16'h0000);
		send_req(OP_ACQUIRE, 8'd255, 16'hFFFF);
		send_req(OP_ACQUIRE, 8'd1, 16'h0000);
		send_req(OP_ACQUIRE, 8'd255, 16'h0000);
		send_req(OP_ACQUIRE, 8'd0, 16'hFFFF);
		send_req(OP_ACQUIRE, 8'd0, 16'h0000);
		send_req(OP_ACQUIRE, 8'd0, 16'h5555);
		send_req(OP_RELEASE, 8'd0, 16'hFFFF);
		send_req(OP_ACQUIRE, 8'd255, 16'hAAAA);
		send_req(OP_ACQUIRE, 8'd255, 16'hFFFF);
		send_req(OP_ACQUIRE, 8'd3, 16'h1234);
		send_req(OP_ACQUIRE, 8'd3, 16'h0F0F);
		send_req(OP_RELEASE, 8'd255, 16'h0000);
		// re-acquire lands in an entry below the one it frees
		send_req(OP_ACQUIRE, 8'd3, 16'h0F0F);
		// release of an owner holding nothing
		send_req(OP_RELEASE, 8'd200, 16'h8001);
		send_req(OP_RELEASE, 8'd3, 16'h7FFE);

		// random: start with a full-table pass, then mix the episodes
		fill_table();
		while (sent < 570) begin
			steady = ($urandom_range(0, 4) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 50)
				contention_burst(30);
			else if (roll < 75)
				noise_burst(24);
			else
				fill_table();
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then give a late or stray result time to appear
		waited = 0;
		while (waiting != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (ENTRIES + 16) @(posedge clk);

		$display("run covered %0d requests: %0d granted, %0d blocked,",
			sent, n_granted, n_blocked);
		$display("  %0d table full, %0d release_all", n_full, n_released);
		if (fail_count == 0 && waiting == 0) begin
			$display("resource_lock_table_unit_tb OK");
		end else begin
			$display("resource_lock_table_unit_tb NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#6000000;
		$display("resource_lock_table_unit_tb NOT OK");
		$finish;
	end

endmodule

>>> resource_lock_table_unit.f
src/rlt_pkg.sv
src/rlt_ram.sv
src/rlt_ctrl.sv
src/rlt_dp.sv
src/resource_lock_table_unit.sv
src/rlt_checker.sv
test/resource_lock_table_unit_checker.sv
test/resource_lock_table_unit_tb.sv
